### hw/rtl/constant_multiply_shift_add_recoder_top_assert.svh
// Assertion macros shared by the recoder RTL.
// Users must have clk and rst (sync, active high) in scope.
`ifndef CONSTANT_MULTIPLY_SHIFT_ADD_RECODER_TOP_ASSERT_SVH
`define CONSTANT_MULTIPLY_SHIFT_ADD_RECODER_TOP_ASSERT_SVH

// same-cycle implication
`define CSDR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSDR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/csdr_pkg.sv
// Shared types, constants and helper functions for the constant recoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csdr_pkg;

  localparam int WORD_BITS_DEF   = 32;
  localparam int ISSUE_WIDTH_DEF = 8;
  localparam int DATA_W          = 32;  // input constant width
  localparam int CNT_W           = 7;   // internal term / shift counters
  localparam int ITEMS_MAX       = 17;  // most items emitted per constant
  localparam int LIMIT_W         = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd3;
  localparam int SHAMT_W         = 5;
  localparam int CNT_OUT_W       = 6;
  localparam int KIND_W          = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TERM = 3'd0,
    KIND_COPY = 3'd1,
    KIND_ZERO = 3'd2,
    KIND_NEG  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  // scanner status toward the sequencer
  typedef struct packed {
    logic             done;
    logic             term;
    logic             sub;
    logic [CNT_W-1:0] term_count;
    logic [CNT_W-1:0] shift_count;
  } scan_stat_t;

  // one result item as held in the output register
  typedef struct packed {
    kind_t                kind;
    logic [SHAMT_W-1:0]   shamt;
    logic                 uses;
    logic                 sub;
    logic                 neg;
    logic [CNT_OUT_W-1:0] ops;
    logic [CNT_OUT_W-1:0] cyc;
    logic                 ok;
    logic                 last;
  } item_t;

  // number of bits needed to represent v (0 for v == 0)
  function automatic logic [3:0] bit_len(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) begin
        n = 4'(k + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csdr_if.sv
// Handshake channel interfaces for the recoder: constant in, result items out.
// Depends on csdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface csdr_in_if import csdr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] constant_value;

  modport source (output valid, output constant_value, input ready);
  modport sink   (input valid, input constant_value, output ready);
endinterface

interface csdr_out_if import csdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    result_kind;
  logic [SHAMT_W-1:0]   shift_amount;
  logic                 uses_shift;
  logic                 subtract;
  logic                 negate_result;
  logic [CNT_OUT_W-1:0] operation_count;
  logic [CNT_OUT_W-1:0] cycle_estimate;
  logic                 within_limit;
  logic                 last;

  modport source (output valid, output result_kind, output shift_amount,
                  output uses_shift, output subtract, output negate_result,
                  output operation_count, output cycle_estimate,
                  output within_limit, output last, input ready);
  modport sink   (input valid, input result_kind, input shift_amount,
                  input uses_shift, input subtract, input negate_result,
                  input operation_count, input cycle_estimate,
                  input within_limit, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/csdr_scan.sv
// Bit-serial run scanner: walks the magnitude from the top bit, one decision
// per step, and reports add/subtract terms. Depends on csdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "constant_multiply_shift_add_recoder_top_assert.svh"

module csdr_scan import csdr_pkg::*; #(
  parameter int  WORD_BITS = WORD_BITS_DEF,
  localparam int MAG_W     = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W,
  localparam int POS_W     = $clog2(MAG_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [MAG_W-1:0] load_mag,
  input  logic             step,
  output scan_stat_t       stat,
  output logic [POS_W-1:0] term_shift
);

  logic [MAG_W-1:0] win;   // bit at MAG_W-1 is the bit at position pos
  logic [POS_W-1:0] pos;
  logic             run;
  logic             run_next;
  logic             adv2;
  logic             term;
  logic             sub;
  logic             done;
  logic [CNT_W-1:0] term_count;
  logic [CNT_W-1:0] shift_count;
  logic             b0, b1, b2, b3, b4;

  assign b0 = win[MAG_W-1];
  assign b1 = win[MAG_W-2];
  assign b2 = win[MAG_W-3];
  assign b3 = win[MAG_W-4];
  assign b4 = win[MAG_W-5];

  assign done = !run && (win == '0);

  always_comb begin
    term       = 1'b0;
    sub        = 1'b0;
    term_shift = pos;
    adv2       = 1'b0;
    run_next   = run;
    if (run) begin
      if (!b1) begin
        if (b2 && b3) begin
          // single zero then a run of two or more: merge, subtract the zero
          term       = 1'b1;
          sub        = 1'b1;
          term_shift = pos - POS_W'(1);
          adv2       = 1'b1;
        end else begin
          // run ends here: subtract its bottom bit
          term     = 1'b1;
          sub      = 1'b1;
          run_next = 1'b0;
        end
      end
    end else if (b0) begin
      term = 1'b1;
      if (b1 && (b2 || (b3 && b4))) begin
        term_shift = pos + POS_W'(1);
        run_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= '0;
      pos         <= '0;
      run         <= 1'b0;
      term_count  <= '0;
      shift_count <= '0;
    end else if (load) begin
      win         <= load_mag;
      pos         <= POS_W'(MAG_W - 1);
      run         <= 1'b0;
      term_count  <= '0;
      shift_count <= '0;
    end else if (step && !done) begin
      win <= adv2 ? (win << 2) : (win << 1);
      pos <= adv2 ? (pos - POS_W'(2)) : (pos - POS_W'(1));
      run <= run_next;
      if (term) begin
        term_count <= term_count + CNT_W'(1);
        if (term_shift != '0) begin
          shift_count <= shift_count + CNT_W'(1);
        end
      end
    end
  end

  assign stat.done        = done;
  assign stat.term        = term;
  assign stat.sub         = sub;
  assign stat.term_count  = term_count;
  assign stat.shift_count = shift_count;

  `CSDR_ASSERT_IMP(a_run_on_one, run, win[MAG_W-1], "scan: run mode off a one bit")
  `CSDR_ASSERT_IMP(a_done_no_term, done, !term, "scan: term reported after scan end")

endmodule

`default_nettype wire

### hw/rtl/csdr_est.sv
// Cycle estimate unit: one shared subtractor forms ceil(x / ISSUE_WIDTH)
// one step per cycle, plus the adder-tree height. Depends on csdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csdr_est import csdr_pkg::*; #(
  parameter int ISSUE_WIDTH = ISSUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 neg,
  input  logic [CNT_W-1:0]     term_count,
  input  logic [CNT_W-1:0]     shift_count,
  output logic                 done,
  output logic [CNT_OUT_W-1:0] cyc_est
);

  localparam int NUM_W = CNT_W + 1;
  localparam int Q_W   = NUM_W + 1;
  localparam logic [3:0]       IW_LEN = bit_len(8'(ISSUE_WIDTH));
  localparam logic [NUM_W-1:0] IW_V   = NUM_W'(ISSUE_WIDTH);
  localparam logic [NUM_W-1:0] DEP_V  = NUM_W'((1 << IW_LEN) - 1);

  logic [NUM_W-1:0] tm1;
  logic [NUM_W-1:0] num;
  logic [Q_W-1:0]   base;
  logic             small_tree;
  logic [NUM_W-1:0] rem;
  logic [Q_W-1:0]   q;
  logic             busy;

  always_comb begin
    tm1        = {1'b0, term_count} - NUM_W'(1);
    small_tree = (tm1 <= DEP_V);
    if (small_tree) begin
      num  = {1'b0, shift_count};
      base = Q_W'(bit_len(tm1)) + Q_W'(neg);
    end else begin
      num  = tm1 - DEP_V + {1'b0, shift_count};
      base = Q_W'(IW_LEN) + Q_W'(neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= num;
      q    <= base;
      busy <= 1'b1;
    end else if (busy) begin
      if (rem == '0) begin
        busy <= 1'b0;
      end else begin
        rem <= (rem > IW_V) ? (rem - IW_V) : '0;
        q   <= q + Q_W'(1);
      end
    end
  end

  assign done    = busy && (rem == '0);
  assign cyc_est = (q > Q_W'(63)) ? CNT_OUT_W'(63) : q[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/constant_multiply_shift_add_recoder_top.sv
// Flow: the scan steps from the top bit down to the lowest set bit, one bit per step (a merge
// covers two), the scan end is seen, the estimate unit forms ceil(n / ISSUE_WIDTH) (n = shifts
// plus terms beyond the adder tree depth), then the last item is loaded before the next input
// transfer is taken. Constants -1, 0, 1 and error cases skip the scan and the estimate.
// Throughput: one constant at a time; scan stalls while the output holds.
// Reset (rst, sync, active high): idle, output empty, limit = 3.
`timescale 1ns / 1ps
`default_nettype none
`include "constant_multiply_shift_add_recoder_top_assert.svh"

module constant_multiply_shift_add_recoder_top import csdr_pkg::*; #(
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int ISSUE_WIDTH = ISSUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  csdr_in_if.sink            operand,
  csdr_out_if.source         result
);

  localparam int MAG_W   = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int POS_W   = $clog2(MAG_W + 1);
  localparam bit ERR_CHK = (WORD_BITS <= DATA_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SPEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_EST  = 5'b01000,
    ST_LAST = 5'b10000
  } state_t;

  state_t               state;
  logic [LIMIT_W-1:0]   limit;
  kind_t                spec_kind;
  kind_t                kind_next;
  logic                 neg;
  logic                 pend_valid;
  logic [POS_W-1:0]     pend_shift;
  logic                 pend_sub;
  logic                 out_valid;
  item_t                out_q;
  item_t                out_val;
  logic                 out_load;
  logic                 out_free;
  logic                 accept;
  logic                 special;
  logic [DATA_W-1:0]    raw;
  logic [DATA_W-1:0]    mag_full;
  logic [MAG_W-1:0]     mag;
  scan_stat_t           stat;
  logic [POS_W-1:0]     term_shift;
  logic                 keep;
  logic                 push_pend;
  logic                 step;
  logic                 est_start;
  logic                 est_done;
  logic [CNT_OUT_W-1:0] est_cyc;
  logic [CNT_W:0]       ops_sum;
  logic [CNT_OUT_W-1:0] ops_sat;
  logic [POS_W+SHAMT_W-1:0] sh_ext;

  assign operand.ready = (state == ST_IDLE);
  assign accept        = operand.valid && operand.ready;
  assign out_free      = !out_valid || result.ready;

  // classify the incoming constant
  always_comb begin
    raw       = operand.constant_value;
    mag_full  = raw[DATA_W-1] ? (~raw + DATA_W'(1)) : raw;
    mag       = mag_full[MAG_W-1:0];
    special   = 1'b1;
    kind_next = KIND_ZERO;
    if (raw == '1) begin
      kind_next = KIND_NEG;
    end else if (raw == DATA_W'(1)) begin
      kind_next = KIND_COPY;
    end else if (raw == '0 || mag == '0) begin
      kind_next = KIND_ZERO;
    end else if (ERR_CHK && mag[MAG_W-1]) begin
      kind_next = KIND_ERR;
    end else begin
      special = 1'b0;
    end
  end

  csdr_scan #(.WORD_BITS(WORD_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && !special),
    .load_mag   (mag),
    .step       (step),
    .stat       (stat),
    .term_shift (term_shift)
  );

  // a new term that is kept displaces the pending one to the output
  assign keep      = (stat.term_count < CNT_W'(ITEMS_MAX));
  assign push_pend = stat.term && keep && pend_valid;
  assign step      = (state == ST_SCAN) && !stat.done && (!push_pend || out_free);
  assign est_start = (state == ST_SCAN) && stat.done;

  csdr_est #(.ISSUE_WIDTH(ISSUE_WIDTH)) u_est (
    .clk         (clk),
    .rst         (rst),
    .start       (est_start),
    .neg         (neg),
    .term_count  (stat.term_count),
    .shift_count (stat.shift_count),
    .done        (est_done),
    .cyc_est     (est_cyc)
  );

  always_comb begin
    ops_sum = {1'b0, stat.shift_count} + {1'b0, stat.term_count}
              + (CNT_W+1)'(neg) - (CNT_W+1)'(1);
    ops_sat = (ops_sum > (CNT_W+1)'(63)) ? CNT_OUT_W'(63) : ops_sum[CNT_OUT_W-1:0];
    sh_ext  = {{SHAMT_W{1'b0}}, pend_shift};
  end

  // output item builder
  always_comb begin
    out_val       = '0;
    out_val.kind  = KIND_TERM;
    out_val.shamt = sh_ext[SHAMT_W-1:0];
    out_val.uses  = (pend_shift != '0);
    out_val.sub   = pend_sub;
    out_load      = 1'b0;
    case (state)
      ST_SPEC: begin
        out_val      = '0;
        out_val.kind = spec_kind;
        out_val.last = 1'b1;
        if (spec_kind != KIND_ERR) begin
          out_val.ops = CNT_OUT_W'(1);
          out_val.cyc = CNT_OUT_W'(1);
          out_val.ok  = (limit != '0);
        end
        out_load = out_free;
      end
      ST_SCAN: begin
        out_load = step && push_pend;
      end
      ST_LAST: begin
        out_val.neg  = neg;
        out_val.ops  = ops_sat;
        out_val.cyc  = est_cyc;
        out_val.ok   = (ops_sat <= limit);
        out_val.last = 1'b1;
        out_load     = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      limit      <= LIMIT_RST;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (out_load) begin
        out_q     <= out_val;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            neg        <= raw[DATA_W-1];
            spec_kind  <= kind_next;
            pend_valid <= 1'b0;
            state      <= special ? ST_SPEC : ST_SCAN;
          end
        end
        ST_SPEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (step && stat.term && keep) begin
            pend_valid <= 1'b1;
            pend_shift <= term_shift;
            pend_sub   <= stat.sub;
          end
          if (stat.done) begin
            state <= ST_EST;
          end
        end
        ST_EST: begin
          if (est_done) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.result_kind     = out_q.kind;
  assign result.shift_amount    = out_q.shamt;
  assign result.uses_shift      = out_q.uses;
  assign result.subtract        = out_q.sub;
  assign result.negate_result   = out_q.neg;
  assign result.operation_count = out_q.ops;
  assign result.cycle_estimate  = out_q.cyc;
  assign result.within_limit    = out_q.ok;
  assign result.last            = out_q.last;

  `CSDR_ASSERT_IMP(a_last_has_item, state == ST_LAST, pend_valid, "top: final item missing")
  `CSDR_ASSERT_IMP(a_no_overwrite, out_load, out_free, "top: output overwritten")
  `CSDR_ASSERT_NXT(a_busy_after_in, accept, !operand.ready, "top: ready right after transfer")

endmodule

`default_nettype wire

### bench/tb_constant_multiply_shift_add_recoder_top.sv
// Self-checking bench for constant_multiply_shift_add_recoder_top: random and
// directed constants in, result items checked against an in-bench recoder.
// Depends on csdr_pkg, csdr_in_if / csdr_out_if and the recoder RTL.
`timescale 1ns / 1ps

module tb_constant_multiply_shift_add_recoder_top;
  import csdr_pkg::*;

  // Expected result items for every accepted constant, checked in order.
  class recoder_scoreboard;
    item_t              pending_items[$];
    logic [LIMIT_W-1:0] op_limit;
    int                 mismatches;
    int                 constants_seen;
    int                 items_checked;
    // mirror of the block's scan state
    logic [31:0]        magnitude_copy;
    bit                 negative_copy;
    int                 shift_tally;
    int                 term_tally;
    int                 scan_copy;
    int                 term_shift[ITEMS_MAX];
    int                 term_sub[ITEMS_MAX];

    function new();
      op_limit = LIMIT_RST;
    endfunction

    function int ones_below(logic [31:0] m, int i);
      int n;
      n = 0;
      while (i >= 0 && i < 32 && m[i]) begin
        n++;
        i--;
      end
      return n;
    endfunction

    function int bits_needed(int v);
      int h;
      h = 0;
      if (v <= 0) begin
        return 0;
      end
      while (h < 32 && (v >> h) != 0) begin
        h++;
      end
      return h;
    endfunction

    function int sat63(int v);
      if (v < 0) begin
        return 0;
      end
      return (v > 63) ? 63 : v;
    endfunction

    function void push_term(int shift, int sub);
      if (shift > 0) begin
        shift_tally++;
      end
      if (term_tally < ITEMS_MAX) begin
        term_shift[term_tally] = shift;
        term_sub[term_tally]   = sub;
      end
      term_tally++;
    endfunction

    function item_t make_item(kind_t k, int sh, int sub, int neg, int ops, int cyc,
                              int ok, int last);
      item_t it;
      it.kind  = k;
      it.shamt = sh[SHAMT_W-1:0];
      it.uses  = (sh > 0);
      it.sub   = sub[0];
      it.neg   = neg[0];
      it.ops   = ops[CNT_OUT_W-1:0];
      it.cyc   = cyc[CNT_OUT_W-1:0];
      it.ok    = ok[0];
      it.last  = last[0];
      return it;
    endfunction

    function void note_constant(logic [31:0] raw);
      logic [31:0] mag;
      int          i, g, t, ops, cyc, dep, n, oc;
      kind_t       k;
      constants_seen++;
      if (raw == 32'hFFFF_FFFF || raw == 32'd0 || raw == 32'd1) begin
        k = (raw == 32'd1) ? KIND_COPY : ((raw == 32'd0) ? KIND_ZERO : KIND_NEG);
        pending_items.push_back(make_item(k, 0, 0, 0, 1, 1, op_limit >= 1, 1));
        return;
      end
      mag            = raw[31] ? -raw : raw;
      magnitude_copy = mag;
      negative_copy  = raw[31];
      shift_tally    = 0;
      term_tally     = 0;
      // only the most negative value keeps bit 31 after the sign is removed
      if (mag[31]) begin
        scan_copy = 31;
        pending_items.push_back(make_item(KIND_ERR, 0, 0, 0, 0, 0, 0, 1));
        return;
      end
      i = 31;
      while (i >= 0) begin
        g = ones_below(mag, i);
        if (g == 0) begin
          i--;
        end else if (g == 1 || (g == 2 && ones_below(mag, i - g - 1) < 2)) begin
          for (int j = 0; j < g; j++) begin
            push_term(i - j, 0);
          end
          i -= g;
        end else begin
          // long run: add the bit above, subtract each bridged zero and the bottom
          push_term(i + 1, 0);
          t = ones_below(mag, i - g - 1);
          while (t >= 2) begin
            push_term(i - g, 1);
            g += 1 + t;
            t = ones_below(mag, i - g - 1);
          end
          push_term((i - g >= 0) ? (i - g + 1) : 0, 1);
          i -= g;
        end
      end
      scan_copy = 0;
      ops = shift_tally + term_tally + negative_copy - 1;
      dep = (1 << bits_needed(ISSUE_WIDTH_DEF)) - 1;
      if (term_tally - 1 <= dep) begin
        cyc = (shift_tally + ISSUE_WIDTH_DEF - 1) / ISSUE_WIDTH_DEF
              + bits_needed(term_tally - 1) + negative_copy;
      end else begin
        cyc = bits_needed(dep)
              + ((term_tally - 1 - dep) + shift_tally + ISSUE_WIDTH_DEF - 1)
                / ISSUE_WIDTH_DEF
              + negative_copy;
      end
      n  = (term_tally < ITEMS_MAX) ? term_tally : ITEMS_MAX;
      oc = sat63(ops);
      for (int j = 0; j < n; j++) begin
        if (j == n - 1) begin
          pending_items.push_back(make_item(KIND_TERM, term_shift[j], term_sub[j],
                                            negative_copy, oc, sat63(cyc),
                                            oc <= op_limit, 1));
        end else begin
          pending_items.push_back(make_item(KIND_TERM, term_shift[j], term_sub[j],
                                            0, 0, 0, 0, 0));
        end
      end
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_item(item_t got);
      item_t want;
      items_checked++;
      if (pending_items.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d shift %0d last %0d",
                 $time, got.kind, got.shamt, got.last);
        return;
      end
      want = pending_items.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("shift_amount", want.shamt, got.shamt);
      compare_field("uses_shift", want.uses, got.uses);
      compare_field("subtract", want.sub, got.sub);
      compare_field("negate_result", want.neg, got.neg);
      compare_field("operation_count", want.ops, got.ops);
      compare_field("cycle_estimate", want.cyc, got.cyc);
      compare_field("within_limit", want.ok, got.ok);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  localparam logic [31:0] DIRECTED [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
    32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    32'h0000_0003, 32'h0000_0007, 32'h5555_5555, 32'h6DB6_DB6D,
    32'h0000_000B, 32'h0000_001B, 32'h0000_000D, 32'h0000_003B,
    32'h0000_0077, 32'h4000_0000, 32'hC000_0000, 32'h3FFF_FFFF,
    32'hAAAA_AAAA, 32'hFFFF_FFFD, 32'hFFFF_FFF9, 32'h0000_0036
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  bit                 quiet_tail;
  int                 limit_settings;

  csdr_in_if  operand_ch();
  csdr_out_if result_ch();

  recoder_scoreboard board = new();

  constant_multiply_shift_add_recoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .operand    (operand_ch),
    .result     (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transfers are sampled before this edge's updates land
  always @(posedge clk) begin : monitor
    item_t seen;
    if (!rst) begin
      if (operand_ch.valid && operand_ch.ready) begin
        board.note_constant(operand_ch.constant_value);
      end
      if (result_ch.valid && result_ch.ready) begin
        seen.kind  = kind_t'(result_ch.result_kind);
        seen.shamt = result_ch.shift_amount;
        seen.uses  = result_ch.uses_shift;
        seen.sub   = result_ch.subtract;
        seen.neg   = result_ch.negate_result;
        seen.ops   = result_ch.operation_count;
        seen.cyc   = result_ch.cycle_estimate;
        seen.ok    = result_ch.within_limit;
        seen.last  = result_ch.last;
        board.check_item(seen);
      end
    end
  end

  // receiver stalls in bursts, none in the tail
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] random_constant();
    logic [31:0] v;
    int          pos;
    int          len;
    int          sel;
    sel = $urandom_range(0, 9);
    v   = '0;
    if (sel < 5) begin
      // runs of ones split by one or two zeros: drives the merge paths
      pos = $urandom_range(2, 30);
      while (pos >= 0) begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len && pos >= 0; j++) begin
          v[pos] = 1'b1;
          pos--;
        end
        pos -= ($urandom_range(0, 3) == 0) ? 2 : 1;
        if ($urandom_range(0, 7) == 0) begin
          break;
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end else if (sel < 7) begin
      v = $urandom();
    end else if (sel < 9) begin
      v = $urandom_range(0, 300);
      if ($urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end else begin
      case ($urandom_range(0, 3))
        0: v = 32'hFFFF_FFFF;
        1: v = 32'h0000_0000;
        2: v = 32'h0000_0001;
        default: v = 32'h8000_0000;
      endcase
    end
    return v;
  endfunction

  // leaves valid high after the transfer; callers lower it when idling
  task automatic send_constant(input logic [31:0] c);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      operand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    operand_ch.valid          <= 1'b1;
    operand_ch.constant_value <= c;
    do begin
      @(posedge clk);
    end while (!(operand_ch.valid && operand_ch.ready));
  endtask

  task automatic drain_results();
    operand_ch.valid <= 1'b0;
    // let the monitor note a transfer taken at this edge first
    @(posedge clk);
    while (board.pending_items.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    board.op_limit  = value;
    limit_settings++;
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limit [5];
    phase_limit[0] = 6'd0;
    phase_limit[1] = 6'd63;
    phase_limit[2] = 6'($urandom_range(0, 63));
    phase_limit[3] = 6'd1;
    phase_limit[4] = 6'd5;
    rst                       <= 1'b1;
    cfg_wr_en                 <= 1'b0;
    cfg_wr_data               <= '0;
    operand_ch.valid          <= 1'b0;
    operand_ch.constant_value <= '0;
    quiet_tail                 = 1'b0;
    limit_settings             = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed values under the reset limit
    foreach (DIRECTED[k]) begin
      send_constant(DIRECTED[k]);
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain_results();
      write_limit(phase_limit[phase]);
      quiet_tail = (phase == 4);
      for (int n = 0; n < 40; n++) begin
        send_constant(random_constant());
        if (phase == 1 && n == 20) begin
          drain_results();
        end
      end
    end
    drain_results();
    repeat (40) @(posedge clk);

    if (board.pending_items.size() != 0) begin
      board.mismatches++;
      $display("%0t: %0d expected result items never arrived", $time,
               board.pending_items.size());
    end
    $display("covered %0d constants, %0d result items, %0d operation limit settings",
             board.constants_seen, board.items_checked, limit_settings);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
